[rtl/fcsw_pkg.sv]
// Package for the FAT16 cluster-chain sector walker.
// Holds field widths, register indexes, mode codes, reset values and the state type.
// No dependencies; every other file imports it.
package fcsw_pkg;

  // Field widths of the request and response channels.
  localparam int unsigned ModeW      = 2;
  localparam int unsigned IndexW     = 12;
  localparam int unsigned ClusterW   = 16;
  localparam int unsigned BytesW     = 32;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned CountW     = 13;

  // Configuration port.
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [CfgIndexW-1:0] CFG_RSVD_COUNT       = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_TABLE_COPIES     = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_SECTORS_PER_TBL  = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_ROOT_ENTRIES     = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_SECTOR_BYTES     = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_CLUSTER_SECTORS  = 3'd5;

  // Request modes.
  localparam logic [ModeW-1:0] MODE_LOAD  = 2'd0;
  localparam logic [ModeW-1:0] MODE_START = 2'd1;
  localparam logic [ModeW-1:0] MODE_NEXT  = 2'd2;

  // Register reset values.
  localparam logic [15:0] RESERVED_RESET = 16'd1;
  localparam logic [7:0]  COPIES_RESET   = 8'd2;
  localparam logic [15:0] SPT_RESET      = 16'd1;
  localparam logic [15:0] ROOT_RESET     = 16'd512;
  localparam logic [12:0] SB_RESET       = 13'd512;
  localparam logic [7:0]  CS_RESET       = 8'd1;

  // First data sector for the reset geometry: 1 + 2 * 1 + ceil(512 * 32 / 512).
  localparam logic [AddrW-1:0] FIRST_DATA_RESET = 32'd35;

  // Cluster value ranges.
  localparam logic [ClusterW-1:0] DATA_CLUSTER_MIN = 16'd2;
  localparam logic [ClusterW-1:0] END_OF_CHAIN_MIN = 16'hFFF8;

  // Root directory sizing: 32-byte entries, ceiling divide over 22 dividend bits.
  localparam int unsigned DirEntryShift = 5;
  localparam int unsigned DivW          = 22;
  localparam int unsigned DivCntW       = 5;

  typedef enum logic [0:0] {
    WALK_IDLE,
    WALK_CALC
  } walk_state_e;

  function automatic logic is_data_cluster(input logic [ClusterW-1:0] c);
    return (c >= DATA_CLUSTER_MIN) && (c < END_OF_CHAIN_MIN);
  endfunction

endpackage

[rtl/fcsw_req_if.sv]
// Request channel of the walker: valid/ready handshake with the input fields.
// Depends on fcsw_pkg for the field widths.
interface fcsw_req_if
  import fcsw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode;
  logic [IndexW-1:0]   table_index;
  logic [ClusterW-1:0] table_value;
  logic [ClusterW-1:0] first_cluster;
  logic [BytesW-1:0]   file_bytes;

  modport source (output valid, mode, table_index, table_value, first_cluster, file_bytes,
                  input ready);
  modport sink   (input valid, mode, table_index, table_value, first_cluster, file_bytes,
                  output ready);
endinterface

[rtl/fcsw_rsp_if.sv]
// Response channel of the walker: valid/ready handshake with the result fields.
// Depends on fcsw_pkg for the field widths.
interface fcsw_rsp_if
  import fcsw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  sector_address;
  logic [CountW-1:0] byte_count;
  logic              has_sector;
  logic              last;
  logic              chain_broken;

  modport source (output valid, sector_address, byte_count, has_sector, last, chain_broken,
                  input ready);
  modport sink   (input valid, sector_address, byte_count, has_sector, last, chain_broken,
                  output ready);
endinterface

[rtl/fat_cluster_chain_sector_walker_top.sv]
// Channel     Dir  Handshake     Payload
// in_i        in   valid/ready   mode, table_index, table_value, first_cluster, file_bytes
// out_o       out  valid/ready   sector_address, byte_count, has_sector, last, chain_broken
// cfg         in   cfg_we_i      cfg_index_i, cfg_data_i (write only)
//
// A next request first reads the allocation table entry of the current cluster from the
// synchronous table memory, then forms the sector address and decides last/chain_broken.
// A configuration write starts a recompute of the first data sector (a bit-serial root
// directory divide), during which no request is taken. Reset clears the walk state; the
// table holds garbage until loaded. A stalled response holds the walker in its address
// state; loads and starts still wait only for the idle state.
// Depends on fcsw_pkg, fcsw_req_if and fcsw_rsp_if.
module fat_cluster_chain_sector_walker_top
  import fcsw_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fcsw_req_if.sink             in_i,
  fcsw_rsp_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned TblAw    = $clog2(TABLE_ENTRIES);
  localparam logic [16:0] TblLimit = 17'(TABLE_ENTRIES);

  // Geometry registers.
  logic [15:0] rsc_q, spt_q, ret_q;
  logic [7:0]  tcc_q, cs_q;
  logic [12:0] sb_q;

  // Geometry recompute.
  logic               geo_load_q, geo_done_q;
  logic [DivCntW-1:0] geo_cnt_q;
  logic [DivW-1:0]    div_quo_q;
  logic [12:0]        div_rem_q;
  logic [23:0]        prod_q;
  logic [AddrW-1:0]   first_data_q;
  logic               geo_busy;
  logic [13:0]        div_trial;
  logic               div_ge;
  logic [DivW-1:0]    div_dividend;

  // Walk state.
  walk_state_e          state_q, state_d;
  logic [ClusterW-1:0]  cur_q;
  logic [7:0]           sic_q;
  logic [BytesW-1:0]    bytes_q;
  logic                 walking_q;
  logic [23:0]          off_q;
  logic [CountW-1:0]    cnt_q;

  // Table memory.
  logic [ClusterW-1:0]  tbl_mem [TABLE_ENTRIES];
  logic [ClusterW-1:0]  tbl_rd_q;
  logic [TblAw-1:0]     tbl_waddr, tbl_raddr;
  logic [16:0]          idx_ext, cur_ext;
  logic                 tbl_we, tbl_re;

  // Control.
  logic in_accept, step_go, out_free;

  // Step results.
  logic [7:0]          per_cluster;
  logic [8:0]          sic_inc;
  logic                cluster_end;
  logic [ClusterW-1:0] next_cluster;
  logic [BytesW-1:0]   bytes_new;
  logic [CountW-1:0]   cnt_d;
  logic                res_has, res_last, res_broken, res_stop;
  logic [AddrW-1:0]    res_addr;
  logic [CountW-1:0]   res_cnt;

  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_has_q, out_last_q, out_broken_q;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsc_q <= RESERVED_RESET;
      tcc_q <= COPIES_RESET;
      spt_q <= SPT_RESET;
      ret_q <= ROOT_RESET;
      sb_q  <= SB_RESET;
      cs_q  <= CS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RSVD_COUNT:       rsc_q <= cfg_data_i;
        CFG_TABLE_COPIES:     tcc_q <= cfg_data_i[7:0];
        CFG_SECTORS_PER_TBL:  spt_q <= cfg_data_i;
        CFG_ROOT_ENTRIES:     ret_q <= cfg_data_i;
        CFG_SECTOR_BYTES:     sb_q  <= cfg_data_i[12:0];
        CFG_CLUSTER_SECTORS:  cs_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Root directory sectors: ceil(entries * 32 / sector_bytes), one quotient bit a cycle.
  assign div_dividend = {1'b0, ret_q, {DirEntryShift{1'b0}}} + DivW'(sb_q) - DivW'(1);
  assign div_trial    = {div_rem_q, div_quo_q[DivW-1]};
  assign div_ge       = div_trial >= {1'b0, sb_q};
  assign geo_busy     = cfg_we_i || geo_load_q || (geo_cnt_q != '0) || geo_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_load_q   <= 1'b0;
      geo_done_q   <= 1'b0;
      geo_cnt_q    <= '0;
      first_data_q <= FIRST_DATA_RESET;
    end else begin
      geo_load_q <= cfg_we_i;
      if (geo_load_q) begin
        geo_cnt_q  <= DivCntW'(DivW);
        geo_done_q <= 1'b0;
      end else if (geo_cnt_q != '0) begin
        geo_cnt_q  <= geo_cnt_q - DivCntW'(1);
        geo_done_q <= (geo_cnt_q == DivCntW'(1));
      end else begin
        geo_done_q <= 1'b0;
      end
      if (geo_done_q) begin
        first_data_q <= 32'(rsc_q) + 32'(prod_q)
                      + ((sb_q == '0) ? 32'd0 : 32'(div_quo_q));
      end
    end
  end

  // Divider datapath and table-area product.
  always_ff @(posedge clk_i) begin
    prod_q <= 24'(tcc_q) * 24'(spt_q);
    if (geo_load_q) begin
      div_quo_q <= div_dividend;
      div_rem_q <= '0;
    end else if (geo_cnt_q != '0) begin
      div_quo_q <= {div_quo_q[DivW-2:0], div_ge};
      div_rem_q <= div_ge ? 13'(div_trial - {1'b0, sb_q}) : div_trial[12:0];
    end
  end

  // Walker state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WALK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      WALK_IDLE: begin
        if (in_accept && (in_i.mode == MODE_NEXT)) state_d = WALK_CALC;
      end
      WALK_CALC: begin
        if (out_free) state_d = WALK_IDLE;
      end
      default: state_d = WALK_IDLE;
    endcase
  end

  // Control outputs.
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_accept = in_i.valid && in_i.ready;
  always_comb begin
    in_i.ready = 1'b0;
    step_go    = 1'b0;
    case (state_q)
      WALK_IDLE: in_i.ready = !geo_busy;
      WALK_CALC: step_go    = out_free;
      default: ;
    endcase
  end

  // Table memory: one write port for loads, one registered read port for the walk.
  assign idx_ext   = 17'(in_i.table_index);
  assign cur_ext   = 17'(cur_q);
  assign tbl_waddr = idx_ext[TblAw-1:0];
  assign tbl_raddr = cur_ext[TblAw-1:0];
  assign tbl_we    = in_accept && (in_i.mode == MODE_LOAD) && (idx_ext < TblLimit);
  assign tbl_re    = in_accept && (in_i.mode == MODE_NEXT);

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= in_i.table_value;
    if (tbl_re) tbl_rd_q <= tbl_mem[tbl_raddr];
  end

  // Next request accepted: cluster offset and byte count are registered.
  assign per_cluster = (cs_q == '0) ? 8'd1 : cs_q;
  assign cnt_d = (bytes_q < 32'(sb_q)) ? bytes_q[CountW-1:0] : sb_q;

  always_ff @(posedge clk_i) begin
    if (tbl_re) begin
      off_q <= 24'(cur_q - DATA_CLUSTER_MIN) * 24'(per_cluster);
      cnt_q <= cnt_d;
    end
  end

  // Address state: address, follow the chain, decide the end of the walk.
  assign sic_inc      = {1'b0, sic_q} + 9'd1;
  assign cluster_end  = sic_inc >= {1'b0, per_cluster};
  assign next_cluster = cluster_end ? tbl_rd_q : cur_q;
  assign bytes_new    = bytes_q - 32'(cnt_q);

  always_comb begin
    res_has    = 1'b0;
    res_last   = 1'b1;
    res_broken = 1'b0;
    res_addr   = '0;
    res_cnt    = '0;
    res_stop   = 1'b1;
    if (!walking_q || (bytes_q == '0) || !is_data_cluster(cur_q)) begin
      res_broken = 1'b0;
    end else if (17'(cur_q) >= TblLimit) begin
      res_broken = 1'b1;
    end else begin
      res_has  = 1'b1;
      res_addr = first_data_q + 32'(off_q) + 32'(sic_q);
      res_cnt  = cnt_q;
      if ((bytes_new == '0) || !is_data_cluster(next_cluster)) begin
        res_broken = 1'b0;
      end else if (17'(next_cluster) >= TblLimit) begin
        res_broken = 1'b1;
      end else begin
        res_last = 1'b0;
        res_stop = 1'b0;
      end
    end
  end

  // Walk state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      sic_q     <= '0;
      bytes_q   <= '0;
      walking_q <= 1'b0;
    end else if (in_accept && (in_i.mode == MODE_START)) begin
      cur_q     <= in_i.first_cluster;
      bytes_q   <= in_i.file_bytes;
      sic_q     <= '0;
      walking_q <= 1'b1;
    end else if (step_go) begin
      if (res_has) begin
        bytes_q <= bytes_new;
        cur_q   <= next_cluster;
        sic_q   <= cluster_end ? 8'd0 : sic_inc[7:0];
      end
      if (res_stop) walking_q <= 1'b0;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      out_addr_q   <= res_addr;
      out_cnt_q    <= res_cnt;
      out_has_q    <= res_has;
      out_last_q   <= res_last;
      out_broken_q <= res_broken;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sector_address = out_addr_q;
  assign out_o.byte_count     = out_cnt_q;
  assign out_o.has_sector     = out_has_q;
  assign out_o.last           = out_last_q;
  assign out_o.chain_broken   = out_broken_q;

`ifndef SYNTHESIS
  // A next request always moves the walker into its address cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_i.mode == MODE_NEXT)) |=> (state_q == WALK_CALC))
    else $error("next request did not enter the address cycle");

  // A response without a sector, or with a broken chain, always ends the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (!out_has_q || out_broken_q)) |-> out_last_q)
    else $error("terminal response not marked last");

  // Once a last response is produced the walker is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && res_last) |=> !walking_q)
    else $error("walker still active after last sector");

  // No request is taken while the first data sector is being recomputed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (geo_cnt_q != '0) |-> !in_accept)
    else $error("request accepted during geometry recompute");
`endif

endmodule

[verif/tb_top.sv]
// Testbench for the FAT16 cluster-chain sector walker: drives table loads, file starts,
// sector requests and geometry writes, predicts every sector response and checks it field by field.
// Depends on fcsw_pkg, fcsw_req_if, fcsw_rsp_if and fat_cluster_chain_sector_walker_top.
module tb_top
  import fcsw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableEntries     = 4096;
  localparam int unsigned CycleLimit       = 300000;
  localparam int unsigned RecomputeCycles  = 30;
  localparam int unsigned SettleCycles     = 8;
  localparam int unsigned HoldOffCycles    = 300;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [IndexW-1:0]   table_index;
    logic [ClusterW-1:0] table_value;
    logic [ClusterW-1:0] first_cluster;
    logic [BytesW-1:0]   file_bytes;
  } walk_req_t;

  typedef struct packed {
    logic [AddrW-1:0]  sector_address;
    logic [CountW-1:0] byte_count;
    logic              has_sector;
    logic              last;
    logic              chain_broken;
  } sector_rsp_t;

  // Mirror of the walker: its own table copy, walk state and geometry, plus the queue of
  // sector responses still owed by the block.
  class sector_scoreboard;
    logic [ClusterW-1:0] fat_copy [TableEntries];
    logic [ClusterW-1:0] cluster;
    logic [7:0]          sector_idx;
    logic [BytesW-1:0]   bytes_left;
    logic                walking;
    logic [15:0]         rsvd_count;
    logic [7:0]          table_copies;
    logic [15:0]         sectors_per_tbl;
    logic [15:0]         root_entries;
    logic [12:0]         sector_bytes;
    logic [7:0]          cluster_sectors;
    sector_rsp_t         expected_q[$];
    int unsigned         failures;

    function new();
      cluster          = '0;
      sector_idx       = '0;
      bytes_left       = '0;
      walking          = 1'b0;
      rsvd_count       = RESERVED_RESET;
      table_copies     = COPIES_RESET;
      sectors_per_tbl  = SPT_RESET;
      root_entries     = ROOT_RESET;
      sector_bytes     = SB_RESET;
      cluster_sectors  = CS_RESET;
      failures         = 0;
    endfunction

    function bit is_file_cluster(input logic [ClusterW-1:0] c);
      return (c >= DATA_CLUSTER_MIN) && (c < END_OF_CHAIN_MIN);
    endfunction

    function void set_register(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
      case (idx)
        CFG_RSVD_COUNT:       rsvd_count       = data;
        CFG_TABLE_COPIES:     table_copies     = data[7:0];
        CFG_SECTORS_PER_TBL:  sectors_per_tbl  = data;
        CFG_ROOT_ENTRIES:     root_entries     = data;
        CFG_SECTOR_BYTES:     sector_bytes     = data[12:0];
        CFG_CLUSTER_SECTORS:  cluster_sectors  = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_request(input walk_req_t r);
      sector_rsp_t rsp;
      logic [31:0] per;
      logic [31:0] root;
      logic [31:0] first;
      logic [31:0] count;
      rsp      = '0;
      rsp.last = 1'b1;
      case (r.mode)
        MODE_LOAD: begin
          // The index field cannot exceed the table, so every load lands.
          fat_copy[r.table_index] = r.table_value;
        end
        MODE_START: begin
          cluster    = r.first_cluster;
          bytes_left = r.file_bytes;
          sector_idx = '0;
          walking    = 1'b1;
        end
        MODE_NEXT: begin
          if (!walking) begin
            // A request while idle only reports the end of the walk.
          end else if (bytes_left == 0 || !is_file_cluster(cluster)) begin
            walking = 1'b0;
          end else if (cluster >= TableEntries) begin
            walking          = 1'b0;
            rsp.chain_broken = 1'b1;
          end else begin
            per   = (cluster_sectors == 0) ? 32'd1 : {24'b0, cluster_sectors};
            root  = (sector_bytes == 0) ? 32'd0 :
                    ({16'b0, root_entries} * 32'd32 + {19'b0, sector_bytes} - 32'd1) /
                    {19'b0, sector_bytes};
            first = {16'b0, rsvd_count} + {24'b0, table_copies} * {16'b0, sectors_per_tbl}
                    + root;
            rsp.sector_address = first + ({16'b0, cluster} - 32'd2) * per + {24'b0, sector_idx};
            count = (bytes_left < {19'b0, sector_bytes}) ? bytes_left : {19'b0, sector_bytes};
            rsp.byte_count = count[CountW-1:0];
            rsp.has_sector = 1'b1;
            bytes_left = bytes_left - count;
            sector_idx = sector_idx + 8'd1;
            // Follow the chain once the cluster is used up.
            if ({24'b0, sector_idx} >= per) begin
              sector_idx = '0;
              cluster    = fat_copy[cluster[IndexW-1:0]];
            end
            // Flag the end on this sector if nothing can follow it.
            if (bytes_left == 0 || !is_file_cluster(cluster)) begin
              walking = 1'b0;
            end else if (cluster >= TableEntries) begin
              walking          = 1'b0;
              rsp.chain_broken = 1'b1;
            end else begin
              rsp.last = 1'b0;
            end
          end
          expected_q.push_back(rsp);
        end
        default: ;
      endcase
    endfunction

    function void check_result(input sector_rsp_t got);
      sector_rsp_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected sector response, sector_address %0h", got.sector_address);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (got.sector_address !== want.sector_address) begin
        $error("sector_address: expected %0h, actual %0h", want.sector_address,
               got.sector_address);
        failures++;
      end
      if (got.byte_count !== want.byte_count) begin
        $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
        failures++;
      end
      if (got.has_sector !== want.has_sector) begin
        $error("has_sector: expected %0b, actual %0b", want.has_sector, got.has_sector);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        failures++;
      end
      if (got.chain_broken !== want.chain_broken) begin
        $error("chain_broken: expected %0b, actual %0b", want.chain_broken, got.chain_broken);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  fcsw_req_if req_bus ();
  fcsw_rsp_if rsp_bus ();

  fat_cluster_chain_sector_walker_top #(
    .TABLE_ENTRIES(TableEntries)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_bus),
    .out_o      (rsp_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  sector_scoreboard sb;

  // Table entries already loaded; every chain link the stimulus creates points at one of
  // these, so the walker never follows an entry that holds garbage.
  bit                written [TableEntries];
  int unsigned       items_sent;
  int unsigned       sender_calm;
  bit                hold_request;
  logic [12:0]       geo_sector_bytes;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Note every accepted request and check every accepted response.
  always @(posedge clk_i) begin
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      sb.note_request(walk_req_t'{mode: req_bus.mode, table_index: req_bus.table_index,
                                  table_value: req_bus.table_value,
                                  first_cluster: req_bus.first_cluster,
                                  file_bytes: req_bus.file_bytes});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      sb.check_result(sector_rsp_t'{sector_address: rsp_bus.sector_address,
                                    byte_count: rsp_bus.byte_count,
                                    has_sector: rsp_bus.has_sector, last: rsp_bus.last,
                                    chain_broken: rsp_bus.chain_broken});
    end
  end

  // Response side: random stalls, calm stretches, and one long hold-off on demand.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned rx_calm;
    hold_left     = 0;
    rx_calm       = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (rx_calm != 0) begin
        rx_calm--;
        rsp_bus.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 299) == 0) rx_calm = 200;
        rsp_bus.ready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic walk_req_t random_request(input logic [ModeW-1:0] mode);
    walk_req_t r;
    r.mode          = mode;
    r.table_index   = IndexW'($urandom);
    r.table_value   = ClusterW'($urandom);
    r.first_cluster = ClusterW'($urandom);
    r.file_bytes    = $urandom;
    return r;
  endfunction

  // Keep a link legal: an unloaded in-table data cluster is moved to the top of the range,
  // where it is either out of the table or an end-of-chain value.
  function automatic logic [ClusterW-1:0] safe_link(input logic [ClusterW-1:0] v, input int self);
    if (v >= DATA_CLUSTER_MIN && v < TableEntries && !written[v[IndexW-1:0]] && int'(v) != self)
      return v | 16'hF000;
    return v;
  endfunction

  // Mostly a small working set of clusters, now and then anywhere in the table.
  function automatic logic [ClusterW-1:0] pick_cluster();
    if ($urandom_range(0, 9) == 0) return ClusterW'($urandom_range(2, TableEntries - 1));
    return ClusterW'($urandom_range(2, 63));
  endfunction

  function automatic logic [ClusterW-1:0] chain_end();
    logic [ClusterW-1:0] c;
    logic [ClusterW-1:0] probe;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = END_OF_CHAIN_MIN + ClusterW'($urandom_range(0, 7));
      4:          c = ClusterW'($urandom_range(0, 1));
      5, 6:       c = ClusterW'($urandom_range(TableEntries, 16'hFFF7));
      default: begin
        // Loop back into a loaded entry, if one turns up.
        c = 16'hFFFF;
        repeat (8) begin
          probe = pick_cluster();
          if (written[probe[IndexW-1:0]]) c = probe;
        end
      end
    endcase
    return c;
  endfunction

  // Offer one request and hold it until the walker takes it.
  task automatic push_request(input walk_req_t r);
    while (sender_calm == 0 && $urandom_range(0, 99) < 17) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    if (sender_calm != 0) sender_calm--;
    else if ($urandom_range(0, 149) == 0) sender_calm = 80;
    if (r.mode != MODE_UNUSED) items_sent++;
    req_bus.valid         <= 1'b1;
    req_bus.mode          <= r.mode;
    req_bus.table_index   <= r.table_index;
    req_bus.table_value   <= r.table_value;
    req_bus.first_cluster <= r.first_cluster;
    req_bus.file_bytes    <= r.file_bytes;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  task automatic load_entry(input logic [IndexW-1:0] idx, input logic [ClusterW-1:0] val);
    walk_req_t r;
    r             = random_request(MODE_LOAD);
    r.table_index = idx;
    r.table_value = val;
    written[idx]  = 1'b1;
    push_request(r);
  endtask

  task automatic start_walk(input logic [ClusterW-1:0] fc, input logic [BytesW-1:0] nbytes);
    walk_req_t r;
    r               = random_request(MODE_START);
    r.first_cluster = fc;
    r.file_bytes    = nbytes;
    push_request(r);
  endtask

  task automatic request_sector();
    push_request(random_request(MODE_NEXT));
  endtask

  // Lower valid and wait until every owed response has come back.
  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Build a chain back to front, start a file on it and ask for a few sectors.
  task automatic run_walk(input int unsigned nexts);
    logic [ClusterW-1:0] link;
    logic [ClusterW-1:0] c;
    logic [BytesW-1:0]   nbytes;
    logic [31:0]         unit;
    link = chain_end();
    repeat ($urandom_range(1, 6)) begin
      c = pick_cluster();
      load_entry(c[IndexW-1:0], link);
      link = c;
    end
    unit = (geo_sector_bytes == 0) ? 32'd512 : {19'b0, geo_sector_bytes};
    case ($urandom_range(0, 19))
      0:       nbytes = '0;
      1, 2:    nbytes = $urandom;
      3:       nbytes = $urandom_range(1, 10);
      4:       nbytes = unit * $urandom_range(1, 4);
      default: nbytes = $urandom_range(1, 6 * unit);
    endcase
    start_walk(link, nbytes);
    repeat (nexts) request_sector();
  endtask

  task automatic run_noise();
    logic [IndexW-1:0] idx;
    case ($urandom_range(0, 3))
      0: begin
        idx = IndexW'($urandom);
        load_entry(idx, safe_link(ClusterW'($urandom), int'(idx)));
      end
      1:       start_walk(safe_link(ClusterW'($urandom), -1), $urandom);
      2:       request_sector();
      default: push_request(random_request(MODE_UNUSED));
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) run_noise();
      else run_walk($urandom_range(1, 10));
    end
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
    cfg_we_i <= 1'b0;
    // The walker recomputes its first data sector after each write.
    repeat (RecomputeCycles) @(posedge clk_i);
  endtask

  // Drain the walker, let it settle, then load a new volume geometry.
  task automatic set_geometry(input logic [15:0] reserved, input logic [7:0] copies,
                              input logic [15:0] spt, input logic [15:0] root,
                              input logic [12:0] sbytes, input logic [7:0] csec);
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    write_register(CFG_RSVD_COUNT, reserved);
    write_register(CFG_TABLE_COPIES, {8'b0, copies});
    write_register(CFG_SECTORS_PER_TBL, spt);
    write_register(CFG_ROOT_ENTRIES, root);
    write_register(CFG_SECTOR_BYTES, {3'b0, sbytes});
    write_register(CFG_CLUSTER_SECTORS, {8'b0, csec});
    geo_sector_bytes = sbytes;
  endtask

  initial begin : stimulus
    sb                    = new();
    items_sent            = 0;
    sender_calm           = 0;
    hold_request          = 1'b0;
    geo_sector_bytes      = SB_RESET;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = '0;
    cfg_data_i            = '0;
    req_bus.valid         = 1'b0;
    req_bus.mode          = MODE_LOAD;
    req_bus.table_index   = '0;
    req_bus.table_value   = '0;
    req_bus.first_cluster = '0;
    req_bus.file_bytes    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests on the reset geometry.
    request_sector();                        // sector request while idle
    push_request(random_request(MODE_UNUSED));
    load_entry(12'd0, 16'hFFFF);
    load_entry(12'd4095, END_OF_CHAIN_MIN);
    load_entry(12'd3, 16'd4095);
    load_entry(12'd2, 16'd3);
    start_walk(16'd2, 32'hFFFF_FFFF);        // chain ends on the top table entry
    repeat (4) request_sector();
    start_walk(16'hFFFF, 32'd100);           // end-of-chain start cluster
    request_sector();
    start_walk(16'd2, 32'd0);                // empty file
    request_sector();
    start_walk(16'hFFF7, 32'd1);             // start outside the table
    request_sector();
    load_entry(12'd5, 16'h1000);
    start_walk(16'd5, 32'd5000);             // chain leaves the table mid-file
    request_sector();
    start_walk(16'd2, 32'd700);
    request_sector();
    start_walk(16'd3, 32'd1);                // new start abandons the walk
    request_sector();

    run_random(120);

    set_geometry(16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF, 13'd4096, 8'd128);
    run_random(100);

    set_geometry(16'd1, 8'd1, 16'd1, 16'd0, 13'd512, 8'd1);
    run_random(40);
    // Block the response side while requests keep coming, then pause until drained.
    hold_request = 1'b1;
    run_walk(16);
    wait_for_results();
    run_random(70);

    // Zero sector size and zero cluster size.
    set_geometry(16'($urandom), 8'($urandom_range(1, 255)), 16'($urandom), 16'($urandom),
                 13'd0, 8'd0);
    run_random(100);

    set_geometry(16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF, 13'd8191, 8'd255);
    run_random(60);

    set_geometry(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                 16'($urandom_range(1, 65535)), 16'($urandom),
                 13'($urandom_range(512, 4096)), 8'($urandom_range(1, 8)));
    run_random(200);

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
